>>> hdl/pulse_width_bit_frame_decoder_assert.svh
// Assertion macros for the pulse width bit frame decoder checker
`ifndef PULSE_WIDTH_BIT_FRAME_DECODER_ASSERT_SVH
`define PULSE_WIDTH_BIT_FRAME_DECODER_ASSERT_SVH

// Check a property on every rising clock edge outside reset
`define PWBFD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a stalled beat keeps valid high and its payload unchanged
`define PWBFD_ASSERT_HOLD(lbl, vld, rdy, sig, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    ((vld) && !(rdy)) |=> ((vld) && $stable(sig))) else $error(msg);

`endif

>>> hdl/pwbfd_pkg.sv
// Shared types and constants for the pulse width bit frame decoder
`timescale 1ns / 1ps

package pwbfd_pkg;

  localparam int DURATION_BITS = 16;
  localparam int DUR_W         = 16;
  localparam logic [DUR_W-1:0] DUR_MASK =
    DUR_W'((33'd1 << DURATION_BITS) - 33'd1);

  localparam int FRAME_LEN = 40;
  localparam int CNT_W     = 6;
  localparam int CFG_IDX_W = 3;

  localparam logic [DUR_W-1:0] ZERO_MIN_RST = 16'd20;
  localparam logic [DUR_W-1:0] ZERO_MAX_RST = 16'd26;
  localparam logic [DUR_W-1:0] ONE_MIN_RST  = 16'd65;
  localparam logic [DUR_W-1:0] ONE_MAX_RST  = 16'd74;
  localparam logic [DUR_W-1:0] RESP_MIN_RST = 16'd72;
  localparam logic [DUR_W-1:0] RESP_MAX_RST = 16'd84;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ZERO_MIN = 3'd0,
    REG_ZERO_MAX = 3'd1,
    REG_ONE_MIN  = 3'd2,
    REG_ONE_MAX  = 3'd3,
    REG_RESP_MIN = 3'd4,
    REG_RESP_MAX = 3'd5
  } reg_idx_e;

  typedef enum logic {
    OP_RESP = 1'b0,
    OP_DATA = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_CSUM_ERR = 2'd1,
    ST_NO_RESP  = 2'd2
  } status_e;

  typedef struct packed {
    logic [DUR_W-1:0] zero_min;
    logic [DUR_W-1:0] zero_max;
    logic [DUR_W-1:0] one_min;
    logic [DUR_W-1:0] one_max;
    logic [DUR_W-1:0] resp_min;
    logic [DUR_W-1:0] resp_max;
  } cfg_t;

  typedef struct packed {
    logic       valid;
    status_e    status;
    logic [7:0] humidity;
    logic [7:0] humidity_frac;
    logic [7:0] temperature;
    logic [7:0] temperature_frac;
    logic [7:0] check_byte;
  } res_t;

endpackage

>>> hdl/pulse_width_bit_frame_decoder.sv
// Top level of the pulse width bit frame decoder
`timescale 1ns / 1ps

// Decodes measured pulse widths from a single-wire humidity/temperature sensor.
// A response beat (tuser 0) inside the response window starts a new frame; one
// outside it returns status 2 with zero bytes. Data beats (tuser 1) become bit 0
// or 1 by width window, or repeat the previous bit, and after the 40th bit the
// five frame bytes come out with status 0 (checksum good) or 1 (checksum bad).
// One beat is taken every cycle unless the input stalls; a beat waits in the input
// register, then its result is loaded into the result register, which drives the
// output port. Input stalls only while a result is held in the result register
// and a further result-producing beat waits behind it. Window registers are
// written through the configuration channel, which is always ready, only while
// the block is idle; the user must keep to this, the block does not enforce it.

module pulse_width_bit_frame_decoder import pwbfd_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [DUR_W-1:0]     s_axis_tdata,  // [15:0] duration
  input  logic                 s_axis_tuser,  // [0] op
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [39:0]          m_axis_tdata,  // humidity, humidity_frac, temperature,
                                              // temperature_frac, check_byte (humidity in [7:0])
  output logic [1:0]           m_axis_tuser,  // [1:0] status
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DUR_W-1:0]     cfg_data_i
);

  cfg_t             cfg;
  res_t             res;
  logic             in_vld_q, in_vld_d;
  logic             in_op_q;
  logic [DUR_W-1:0] in_dur_q;
  logic             out_vld_q, out_vld_d;
  res_t             out_q;
  logic             out_free, step;

  assign cfg_ready_o = 1'b1;

  pwbfd_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_valid_i),
    .wr_idx_i  (cfg_index_i),
    .wr_data_i (cfg_data_i),
    .cfg_o     (cfg)
  );

  pwbfd_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .item_op_i  (in_op_q),
    .item_dur_i (in_dur_q),
    .cfg_i      (cfg),
    .res_o      (res)
  );

  assign out_free      = !out_vld_q || m_axis_tready;
  assign step          = in_vld_q && (!res.valid || out_free);
  assign s_axis_tready = !in_vld_q || step;
  assign in_vld_d      = s_axis_tready ? s_axis_tvalid : in_vld_q;
  assign out_vld_d     = out_free ? (step && res.valid) : out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // hold payload until the next beat lands; load the result register when a result steps out
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_op_q  <= s_axis_tuser;
      in_dur_q <= s_axis_tdata;
    end
    if (out_free && step && res.valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_q.status;
  assign m_axis_tdata  = {out_q.check_byte, out_q.temperature_frac, out_q.temperature,
                          out_q.humidity_frac, out_q.humidity};

endmodule

>>> hdl/pwbfd_cfg.sv
// Window configuration registers of the pulse width bit frame decoder
`timescale 1ns / 1ps

module pwbfd_cfg import pwbfd_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 wr_en_i,
  input  logic [CFG_IDX_W-1:0] wr_idx_i,
  input  logic [DUR_W-1:0]     wr_data_i,
  output cfg_t                 cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (reg_idx_e'(wr_idx_i))
        REG_ZERO_MIN: cfg_d.zero_min = wr_data_i;
        REG_ZERO_MAX: cfg_d.zero_max = wr_data_i;
        REG_ONE_MIN:  cfg_d.one_min  = wr_data_i;
        REG_ONE_MAX:  cfg_d.one_max  = wr_data_i;
        REG_RESP_MIN: cfg_d.resp_min = wr_data_i;
        REG_RESP_MAX: cfg_d.resp_max = wr_data_i;
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.zero_min <= ZERO_MIN_RST;
      cfg_q.zero_max <= ZERO_MAX_RST;
      cfg_q.one_min  <= ONE_MIN_RST;
      cfg_q.one_max  <= ONE_MAX_RST;
      cfg_q.resp_min <= RESP_MIN_RST;
      cfg_q.resp_max <= RESP_MAX_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> hdl/pwbfd_core.sv
// Pulse classification, frame shift register and checksum of the decoder
`timescale 1ns / 1ps

module pwbfd_core import pwbfd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic             item_op_i,
  input  logic [DUR_W-1:0] item_dur_i,
  input  cfg_t             cfg_i,
  output res_t             res_o
);

  logic                 armed_q, armed_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [FRAME_LEN-1:0] frame_q, frame_d;
  logic                 last_bit_q, last_bit_d;

  logic [DUR_W-1:0]     dur;
  logic                 resp_hit, zero_hit, one_hit, bit_val, done;
  logic [FRAME_LEN-1:0] frame_nx;
  logic [9:0]           sum;

  assign dur      = item_dur_i & DUR_MASK;
  assign resp_hit = (dur >= cfg_i.resp_min) && (dur <= cfg_i.resp_max);
  assign zero_hit = (dur >= cfg_i.zero_min) && (dur <= cfg_i.zero_max);
  assign one_hit  = (dur >= cfg_i.one_min) && (dur <= cfg_i.one_max);
  assign bit_val  = zero_hit ? 1'b0 : (one_hit ? 1'b1 : last_bit_q);
  assign frame_nx = {frame_q[FRAME_LEN-2:0], bit_val};
  assign done     = armed_q && (cnt_q == CNT_W'(FRAME_LEN - 1));
  assign sum      = 10'(frame_nx[39:32]) + 10'(frame_nx[31:24])
                  + 10'(frame_nx[23:16]) + 10'(frame_nx[15:8]);

  always_comb begin
    res_o = '0;
    if (op_e'(item_op_i) == OP_RESP) begin
      res_o.valid  = !resp_hit;
      res_o.status = ST_NO_RESP;
    end else begin
      res_o.valid            = done;
      res_o.status           = ((sum == 10'(frame_nx[7:0])) && (sum != 10'd0)) ?
                               ST_OK : ST_CSUM_ERR;
      res_o.humidity         = frame_nx[39:32];
      res_o.humidity_frac    = frame_nx[31:24];
      res_o.temperature      = frame_nx[23:16];
      res_o.temperature_frac = frame_nx[15:8];
      res_o.check_byte       = frame_nx[7:0];
    end
  end

  always_comb begin
    armed_d    = armed_q;
    cnt_d      = cnt_q;
    frame_d    = frame_q;
    last_bit_d = last_bit_q;
    if (step_i) begin
      if (op_e'(item_op_i) == OP_RESP) begin
        armed_d = resp_hit;
        cnt_d   = '0;
        if (resp_hit) begin
          frame_d = '0;
        end
      end else if (armed_q) begin
        last_bit_d = bit_val;
        frame_d    = frame_nx;
        if (done) begin
          armed_d = 1'b0;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q    <= 1'b0;
      cnt_q      <= '0;
      frame_q    <= '0;
      last_bit_q <= 1'b0;
    end else begin
      armed_q    <= armed_d;
      cnt_q      <= cnt_d;
      frame_q    <= frame_d;
      last_bit_q <= last_bit_d;
    end
  end

endmodule

>>> hdl/pwbfd_checker.sv
// Port-level assertions for the pulse width bit frame decoder
`timescale 1ns / 1ps
`include "pulse_width_bit_frame_decoder_assert.svh"

module pwbfd_checker import pwbfd_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  logic [9:0]  byte_sum;
  logic [41:0] m_beat;
  logic        sum_good, nr_beat, ok_beat, bad_beat;

  assign byte_sum = 10'(m_axis_tdata[7:0]) + 10'(m_axis_tdata[15:8])
                  + 10'(m_axis_tdata[23:16]) + 10'(m_axis_tdata[31:24]);
  assign sum_good = (byte_sum == 10'(m_axis_tdata[39:32])) && (byte_sum != 10'd0);
  assign m_beat   = {m_axis_tuser, m_axis_tdata};
  assign nr_beat  = m_axis_tvalid && (m_axis_tuser == ST_NO_RESP);
  assign ok_beat  = m_axis_tvalid && (m_axis_tuser == ST_OK);
  assign bad_beat = m_axis_tvalid && (m_axis_tuser == ST_CSUM_ERR);

  `PWBFD_ASSERT_HOLD(a_out_hold, m_axis_tvalid, m_axis_tready, m_beat, "result beat changed")
  `PWBFD_ASSERT(a_no_resp_zero, nr_beat |-> (m_axis_tdata == '0), "no-response beat with bytes")
  `PWBFD_ASSERT(a_ok_sum, ok_beat |-> sum_good, "ok status with bad checksum")
  `PWBFD_ASSERT(a_bad_sum, bad_beat |-> !sum_good, "checksum error on good frame")

endmodule

bind pulse_width_bit_frame_decoder pwbfd_checker u_pwbfd_checker (.*);

>>> test/pulse_width_bit_frame_decoder_test.sv
// Self-checking testbench for the pulse width bit frame decoder
`timescale 1ns / 1ps

module pulse_width_bit_frame_decoder_test;
  import pwbfd_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int SINK_HOLD = 300;
  localparam int MAX_REPORTS = 40;

  typedef struct {
    op_e         op;
    logic [15:0] width;
  } pulse_t;

  typedef struct {
    status_e    status;
    logic [7:0] humidity;
    logic [7:0] humidity_frac;
    logic [7:0] temperature;
    logic [7:0] temperature_frac;
    logic [7:0] check_byte;
  } reading_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [DUR_W-1:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [DUR_W-1:0] cfg_data_i = '0;

  pulse_width_bit_frame_decoder uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // decoder state as predicted
  cfg_t        win;
  bit          frame_open = 1'b0;
  int          bits_seen = 0;
  logic [39:0] frame_word = '0;
  logic        prev_bit = 1'b0;

  pulse_t   pulses_to_send[$];
  reading_t readings_due[$];
  int       mismatches = 0;

  bit src_idle_on = 1'b1;
  bit sink_idle_on = 1'b1;
  bit burst_mode = 1'b0;
  int hold_req = 0;
  int hold_ack = 0;
  int src_gap = 0;
  int sink_gap = 0;
  int sink_hold = 0;
  int quiet_cycles = 0;

  function automatic bit in_range(logic [15:0] w, logic [15:0] lo, logic [15:0] hi);
    return w >= lo && w <= hi;
  endfunction

  task automatic decode_pulse(op_e op, logic [15:0] w);
    reading_t   r;
    logic [9:0] sum;
    if (op == OP_RESP) begin
      if (in_range(w, win.resp_min, win.resp_max)) begin
        frame_open = 1'b1;
        bits_seen = 0;
        frame_word = '0;
      end else begin
        frame_open = 1'b0;
        bits_seen = 0;
        r = '{ST_NO_RESP, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
        readings_due.push_back(r);
      end
    end else if (frame_open) begin
      if (in_range(w, win.zero_min, win.zero_max)) begin
        prev_bit = 1'b0;
      end else if (in_range(w, win.one_min, win.one_max)) begin
        prev_bit = 1'b1;
      end
      frame_word = {frame_word[38:0], prev_bit};
      bits_seen++;
      if (bits_seen == FRAME_LEN) begin
        r.humidity = frame_word[39:32];
        r.humidity_frac = frame_word[31:24];
        r.temperature = frame_word[23:16];
        r.temperature_frac = frame_word[15:8];
        r.check_byte = frame_word[7:0];
        sum = 10'(r.humidity) + 10'(r.humidity_frac) + 10'(r.temperature)
            + 10'(r.temperature_frac);
        r.status = (sum == 10'(r.check_byte) && sum != 10'd0) ? ST_OK : ST_CSUM_ERR;
        readings_due.push_back(r);
        frame_open = 1'b0;
        bits_seen = 0;
      end
    end
  endtask

  task automatic check_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      if (mismatches < MAX_REPORTS) $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endtask

  function automatic int pick_gap(bit on);
    int r;
    if (!on) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // driver: offer pulses, predict on each accepted beat
  always @(posedge clk_i) begin
    pulse_t nxt;
    bit     offer;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        decode_pulse(op_e'(s_axis_tuser), s_axis_tdata);
      end
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        offer = 1'b0;
        if (src_gap > 0) begin
          src_gap--;
        end else if (pulses_to_send.size() != 0) begin
          nxt = pulses_to_send.pop_front();
          offer = 1'b1;
          src_gap = burst_mode ? 0 : pick_gap(src_idle_on);
        end
        s_axis_tvalid <= offer;
        if (offer) begin
          s_axis_tdata <= nxt.width;
          s_axis_tuser <= nxt.op;
        end
      end
    end
  end

  // monitor: compare each result beat, pace tready
  always @(posedge clk_i) begin
    reading_t want;
    reading_t got;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.status = status_e'(m_axis_tuser);
        got.humidity = m_axis_tdata[7:0];
        got.humidity_frac = m_axis_tdata[15:8];
        got.temperature = m_axis_tdata[23:16];
        got.temperature_frac = m_axis_tdata[31:24];
        got.check_byte = m_axis_tdata[39:32];
        if (readings_due.size() == 0) begin
          if (mismatches < MAX_REPORTS) $error("result beat with no reading due");
          mismatches++;
        end else begin
          want = readings_due.pop_front();
          check_field("status", want.status, got.status);
          check_field("humidity", want.humidity, got.humidity);
          check_field("humidity_frac", want.humidity_frac, got.humidity_frac);
          check_field("temperature", want.temperature, got.temperature);
          check_field("temperature_frac", want.temperature_frac, got.temperature_frac);
          check_field("check_byte", want.check_byte, got.check_byte);
        end
      end
      if (hold_ack != hold_req) begin
        hold_ack = hold_req;
        sink_hold = SINK_HOLD;
      end
      if (sink_hold > 0) begin
        sink_hold--;
        m_axis_tready <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        sink_gap = pick_gap(sink_idle_on);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(reg_idx_e idx, logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_ZERO_MIN: win.zero_min = val;
      REG_ZERO_MAX: win.zero_max = val;
      REG_ONE_MIN:  win.one_min = val;
      REG_ONE_MAX:  win.one_max = val;
      REG_RESP_MIN: win.resp_min = val;
      REG_RESP_MAX: win.resp_max = val;
      default: ;
    endcase
  endtask

  task automatic load_windows(cfg_t c);
    write_reg(REG_ZERO_MIN, c.zero_min);
    write_reg(REG_ZERO_MAX, c.zero_max);
    write_reg(REG_ONE_MIN, c.one_min);
    write_reg(REG_ONE_MAX, c.one_max);
    write_reg(REG_RESP_MIN, c.resp_min);
    write_reg(REG_RESP_MAX, c.resp_max);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    do begin
      @(posedge clk_i);
      #1;
    end while (pulses_to_send.size() != 0 || s_axis_tvalid || readings_due.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic push_pulse(op_e op, logic [15:0] w);
    pulse_t p;
    p.op = op;
    p.width = w;
    pulses_to_send.push_back(p);
  endtask

  function automatic logic [15:0] bit_width(logic b);
    logic [15:0] lo;
    logic [15:0] hi;
    lo = b ? win.one_min : win.zero_min;
    hi = b ? win.one_max : win.zero_max;
    if (lo > hi) return 16'($urandom);
    case ($urandom_range(0, 9))
      0: return lo;
      1: return hi;
      default: return 16'($urandom_range(hi, lo));
    endcase
  endfunction

  function automatic logic [15:0] good_resp_width();
    if (win.resp_min > win.resp_max) return 16'($urandom);
    case ($urandom_range(0, 5))
      0: return win.resp_min;
      1: return win.resp_max;
      default: return 16'($urandom_range(win.resp_max, win.resp_min));
    endcase
  endfunction

  function automatic bit bad_resp_width(output logic [15:0] w);
    w = '0;
    if (win.resp_min > win.resp_max) begin
      w = 16'($urandom);
      return 1'b1;
    end
    if (win.resp_min > 0 && (win.resp_max == 16'hFFFF || $urandom_range(0, 1) == 0)) begin
      w = ($urandom_range(0, 3) == 0) ? win.resp_min - 16'd1
                                      : 16'($urandom_range(win.resp_min - 16'd1, 0));
      return 1'b1;
    end
    if (win.resp_max < 16'hFFFF) begin
      w = ($urandom_range(0, 3) == 0) ? win.resp_max + 16'd1
                                      : 16'($urandom_range(16'hFFFF, win.resp_max + 16'd1));
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [39:0] pick_frame_word();
    logic [7:0] b [4];
    logic [9:0] sum;
    logic [7:0] csum;
    int         kind;
    kind = $urandom_range(0, 3);
    sum = '0;
    for (int k = 0; k < 4; k++) begin
      b[k] = (kind == 0) ? 8'($urandom_range(0, 63)) : 8'($urandom);
      sum += 10'(b[k]);
    end
    case (kind)
      0, 1: csum = sum[7:0];
      2: csum = 8'($urandom);
      default: csum = sum[7:0] + (($urandom_range(0, 1) == 0) ? 8'd1 : 8'hFF);
    endcase
    return {b[0], b[1], b[2], b[3], csum};
  endfunction

  task automatic push_bits(logic [39:0] word, int count, int noise_pct);
    for (int i = 39; i > 39 - count; i--) begin
      if ($urandom_range(0, 99) < noise_pct) push_pulse(OP_DATA, 16'($urandom));
      else push_pulse(OP_DATA, bit_width(word[i]));
    end
  endtask

  task automatic push_frame(logic [39:0] word, int noise_pct);
    push_pulse(OP_RESP, good_resp_width());
    push_bits(word, FRAME_LEN, noise_pct);
  endtask

  task automatic fill_random(int target);
    int          r;
    logic [15:0] w;
    while (pulses_to_send.size() < target) begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        push_frame(pick_frame_word(), ($urandom_range(0, 2) == 0) ? 0 : 6);
      end else if (r < 70) begin
        if (bad_resp_width(w)) push_pulse(OP_RESP, w);
      end else if (r < 78) begin
        push_pulse(OP_RESP, good_resp_width());
        push_bits(pick_frame_word(), $urandom_range(0, 39), 5);
      end else if (r < 84) begin
        push_pulse(OP_DATA, 16'($urandom));
      end else if (r < 90) begin
        push_pulse(OP_RESP, good_resp_width());
        push_bits(pick_frame_word(), $urandom_range(1, 39), 5);
        push_frame(pick_frame_word(), 0);
      end else begin
        push_pulse(op_e'($urandom_range(0, 1)), 16'($urandom));
      end
    end
  endtask

  initial begin
    cfg_t plan [10];
    int   items;
    logic [15:0] w;

    win = '{zero_min: ZERO_MIN_RST, zero_max: ZERO_MAX_RST, one_min: ONE_MIN_RST,
            one_max: ONE_MAX_RST, resp_min: RESP_MIN_RST, resp_max: RESP_MAX_RST};

    plan[0] = '{zero_min: 0, zero_max: 30, one_min: 31, one_max: 16'hFFFF,
                resp_min: 0, resp_max: 16'hFFFF};
    plan[1] = '{zero_min: 10, zero_max: 100, one_min: 50, one_max: 200,
                resp_min: 100, resp_max: 100};
    plan[2] = '{zero_min: 16'hFFFF, zero_max: 0, one_min: 40, one_max: 60,
                resp_min: 16'hFFFF, resp_max: 16'hFFFF};
    plan[3] = '{zero_min: 0, zero_max: 0, one_min: 16'hFFFF, one_max: 16'hFFFF,
                resp_min: 100, resp_max: 50};
    for (int p = 4; p < 8; p++) begin
      plan[p].zero_min = 16'($urandom_range(0, 200));
      plan[p].zero_max = plan[p].zero_min + 16'($urandom_range(0, 50));
      plan[p].one_min = plan[p].zero_max + 16'($urandom_range(1, 100));
      plan[p].one_max = plan[p].one_min + 16'($urandom_range(0, 100));
      plan[p].resp_min = 16'($urandom_range(0, 500));
      plan[p].resp_max = plan[p].resp_min + 16'($urandom_range(0, 200));
    end
    plan[8] = cfg_t'({$urandom, $urandom, $urandom});
    plan[9] = win;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset windows, special cases first
    push_pulse(OP_DATA, 16'd70);
    push_pulse(OP_RESP, 16'd0);
    push_pulse(OP_RESP, 16'hFFFF);
    push_pulse(OP_RESP, 16'd71);
    push_pulse(OP_RESP, 16'd85);
    push_pulse(OP_RESP, 16'd72);
    push_pulse(OP_DATA, 16'd65);
    push_pulse(OP_DATA, 16'd20);
    push_pulse(OP_DATA, 16'd0);
    push_pulse(OP_DATA, 16'd74);
    push_pulse(OP_DATA, 16'hFFFF);
    push_pulse(OP_DATA, 16'd26);
    push_pulse(OP_DATA, 16'd27);
    push_pulse(OP_DATA, 16'd64);
    push_pulse(OP_DATA, 16'd19);
    push_pulse(OP_DATA, 16'd75);
    push_pulse(OP_RESP, 16'd84);
    push_bits(40'd0, FRAME_LEN, 0);
    push_pulse(OP_DATA, 16'd70);
    push_frame({8'd255, 8'd1, 8'd0, 8'd0, 8'd0}, 0);
    push_frame({8'd40, 8'd5, 8'd22, 8'd7, 8'd74}, 0);
    push_pulse(OP_RESP, 16'd80);
    push_bits(40'hFF_FFFF_FFFF, 20, 0);
    push_pulse(OP_RESP, 16'd10);
    push_pulse(OP_DATA, 16'd70);
    drain();

    for (int p = 0; p < 10; p++) begin
      load_windows(plan[p]);
      src_idle_on = $urandom_range(0, 3) != 0;
      sink_idle_on = $urandom_range(0, 3) != 0;
      if (p == 9) begin
        // back up the result path while the source keeps streaming
        burst_mode = 1'b1;
        hold_req++;
        for (int k = 0; k < 40; k++) begin
          if (bad_resp_width(w)) push_pulse(OP_RESP, w);
        end
        drain();
        burst_mode = 1'b0;
      end
      items = (p == 3) ? 30 : 110;
      fill_random(items);
      drain();
    end

    repeat (6) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> pulse_width_bit_frame_decoder.f
+incdir+hdl
hdl/pwbfd_pkg.sv
hdl/pwbfd_cfg.sv
hdl/pwbfd_core.sv
hdl/pulse_width_bit_frame_decoder.sv
hdl/pwbfd_checker.sv
test/pulse_width_bit_frame_decoder_test.sv
